@@ rtl/prime_sieve_generator_top_defines.svh @@
// assertion macros shared by the prime sieve generator checker
// depends on nothing; the including module provides clk and rst_n
`ifndef PRIME_SIEVE_GENERATOR_TOP_DEFINES_SVH
`define PRIME_SIEVE_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define PSG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prime sieve generator check failed");

// next-cycle implication, sampled on the rising clock edge
`define PSG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prime sieve generator check failed");

`endif

@@ rtl/psg_pkg.sv @@
// types, constants and microcode program of the prime sieve generator
// depends on nothing
`default_nettype none

package psg_pkg;

    localparam int LIMIT_W = 20;
    localparam int MAXC_W  = 17;
    localparam int VALUE_W = 20;
    localparam int INDEX_W = 16;
    localparam int COUNT_W = 17;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'hFFFFF;
    localparam logic [MAXC_W-1:0]  MAXC_RESET  = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT = 1'b1;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_ACCEPT,
        ACT_RUN_INIT,
        ACT_CLEAR,
        ACT_CLEAN,
        ACT_CAND_INC,
        ACT_EMIT_PRIME,
        ACT_MARK,
        ACT_EMIT_DONE
    } act_t;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_START,
        COND_NO_RESTART,
        COND_CLEAN,
        COND_CLR_MORE,
        COND_NO_REQ,
        COND_CAPPED,
        COND_OVER,
        COND_PRIME,
        COND_MULT_IN
    } cond_t;

    localparam int STEP_W    = 4;
    localparam int NUM_STEPS = 16;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t S_IDLE     = 4'd0;
    localparam step_t S_DISPATCH = 4'd1;
    localparam step_t S_INIT     = 4'd2;
    localparam step_t S_CLEAR    = 4'd3;
    localparam step_t S_CLEARED  = 4'd4;
    localparam step_t S_CHECK    = 4'd5;
    localparam step_t S_SCAN     = 4'd6;
    localparam step_t S_TEST     = 4'd7;
    localparam step_t S_NEXT     = 4'd8;
    localparam step_t S_FOUND    = 4'd9;
    localparam step_t S_MARK     = 4'd10;
    localparam step_t S_ADVANCE  = 4'd11;
    localparam step_t S_DONE     = 4'd12;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } ucode_t;

    // jump to target when the condition holds, else go to the next step
    localparam ucode_t UPROG [NUM_STEPS] = '{
        '{act: ACT_ACCEPT,     cond: COND_NO_START,   target: S_IDLE},
        '{act: ACT_NONE,       cond: COND_NO_RESTART, target: S_CHECK},
        '{act: ACT_RUN_INIT,   cond: COND_CLEAN,      target: S_CLEARED},
        '{act: ACT_CLEAR,      cond: COND_CLR_MORE,   target: S_CLEAR},
        '{act: ACT_CLEAN,      cond: COND_NO_REQ,     target: S_IDLE},
        '{act: ACT_NONE,       cond: COND_CAPPED,     target: S_DONE},
        '{act: ACT_NONE,       cond: COND_OVER,       target: S_DONE},
        '{act: ACT_NONE,       cond: COND_PRIME,      target: S_FOUND},
        '{act: ACT_CAND_INC,   cond: COND_ALWAYS,     target: S_SCAN},
        '{act: ACT_EMIT_PRIME, cond: COND_NEVER,      target: S_IDLE},
        '{act: ACT_MARK,       cond: COND_MULT_IN,    target: S_MARK},
        '{act: ACT_CAND_INC,   cond: COND_ALWAYS,     target: S_IDLE},
        '{act: ACT_EMIT_DONE,  cond: COND_ALWAYS,     target: S_IDLE},
        '{act: ACT_NONE,       cond: COND_ALWAYS,     target: S_IDLE},
        '{act: ACT_NONE,       cond: COND_ALWAYS,     target: S_IDLE},
        '{act: ACT_NONE,       cond: COND_ALWAYS,     target: S_IDLE}
    };

endpackage

`default_nettype wire

@@ rtl/prime_sieve_generator_top.sv @@
// prime sieve generator: one prime (or a done result) per start transfer; depends on psg_pkg
// a restart first clears the map, if any entry is marked, up to the highest address marked
//   since the last clearing; candidates are then scanned upward until a prime is found or the cap or limit ends the run
// marking: after a prime strobe busy stays high while its multiples are marked
// reset: registers set to their reset values, then a clearing pass over the whole map with busy high
// results are strobed for one cycle on valid; the receiver cannot stall
`default_nettype none

module prime_sieve_generator_top
    import psg_pkg::*;
#(
    parameter int SIEVE_SIZE = 1048576,
    parameter int MAX_COUNT  = 65536
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // request channel
    input  wire logic                 start,
    input  wire logic                 restart,
    output logic                      busy,
    // result channel
    output logic                      valid,
    output logic [VALUE_W-1:0]        prime_value,
    output logic [INDEX_W-1:0]        prime_index,
    output logic                      done_res,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    // map address width, candidate width (holds limit plus one), square width
    localparam int AW  = $clog2(SIEVE_SIZE);
    localparam int CW  = AW + 1;
    localparam int MW  = 2 * AW;
    localparam int LCW = (AW > LIMIT_W) ? AW : LIMIT_W;
    localparam logic [LCW-1:0] TOP_ADDR_W = LCW'(SIEVE_SIZE - 1);
    localparam logic [AW-1:0]  TOP_ADDR   = AW'(SIEVE_SIZE - 1);
    localparam logic [20:0]    MAX_COUNT_W = 21'(MAX_COUNT);

    // configuration registers
    logic [LIMIT_W-1:0] limit_reg;
    logic [MAXC_W-1:0]  max_count_reg;

    // sequencer
    step_t  pc_reg, pc_next;
    ucode_t uword;
    logic   cond_hit;

    // datapath registers
    logic               restart_reg, restart_next;
    logic               req_reg, req_next;
    logic [CW-1:0]      cand_reg, cand_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [MW-1:0]      mult_reg, mult_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [AW-1:0]      hwm_reg, hwm_next;
    logic               dirty_reg, dirty_next;

    // result registers
    logic               valid_reg, valid_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [INDEX_W-1:0] index_reg, index_next;
    logic               done_reg, done_next;

    // composite map
    logic          sieve_mem [SIEVE_SIZE];
    logic          rd_bit_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;

    // derived values
    logic [LCW-1:0]       lim_wide;
    logic [AW-1:0]        lim_eff;
    logic                 capped;
    logic                 over;
    logic                 mult_in;
    logic [AW-1:0]        cand_lo;
    logic [MW-1:0]        square;
    logic [CW+VALUE_W-1:0] cand_pad;

    assign busy        = (pc_reg != S_IDLE);
    assign valid       = valid_reg;
    assign prime_value = value_reg;
    assign prime_index = index_reg;
    assign done_res    = done_reg;

    // the effective limit never reaches past the end of the map
    assign lim_wide = LCW'(limit_reg);
    assign lim_eff  = (lim_wide > TOP_ADDR_W) ? TOP_ADDR : lim_wide[AW-1:0];

    // cap is the smaller of the register and the build-time maximum
    assign capped  = (count_reg >= max_count_reg) || (21'(count_reg) >= MAX_COUNT_W);
    assign over    = (cand_reg > CW'(lim_eff));
    assign mult_in = (mult_reg <= MW'(lim_eff));
    assign cand_lo = cand_reg[AW-1:0];
    assign square  = cand_lo * cand_lo;
    assign cand_pad = {{VALUE_W{1'b0}}, cand_reg};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            max_count_reg <= MAXC_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LIMIT:     limit_reg     <= cfg_data[LIMIT_W-1:0];
                CFG_MAX_COUNT: max_count_reg <= cfg_data[MAXC_W-1:0];
                default:       ;
            endcase
        end
    end

    // map port: one write, one registered read at the candidate
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sieve_mem[mem_waddr] <= mem_wdata;
        end
        rd_bit_reg <= sieve_mem[cand_lo];
    end

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= S_CLEAR;     // map contents are unknown after power-up
            restart_reg  <= 1'b0;
            req_reg      <= 1'b0;
            cand_reg     <= CW'(2);
            count_reg    <= '0;
            mult_reg     <= '0;
            clr_addr_reg <= '0;
            hwm_reg      <= TOP_ADDR;
            dirty_reg    <= 1'b1;
            valid_reg    <= 1'b0;
            value_reg    <= '0;
            index_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            pc_reg       <= pc_next;
            restart_reg  <= restart_next;
            req_reg      <= req_next;
            cand_reg     <= cand_next;
            count_reg    <= count_next;
            mult_reg     <= mult_next;
            clr_addr_reg <= clr_addr_next;
            hwm_reg      <= hwm_next;
            dirty_reg    <= dirty_next;
            valid_reg    <= valid_next;
            value_reg    <= value_next;
            index_reg    <= index_next;
            done_reg     <= done_next;
        end
    end

    // control word fetch and branch
    always_comb
    begin
        uword = UPROG[pc_reg];
        unique case (uword.cond)
            COND_NEVER:      cond_hit = 1'b0;
            COND_ALWAYS:     cond_hit = 1'b1;
            COND_NO_START:   cond_hit = !start;
            COND_NO_RESTART: cond_hit = !restart_reg;
            COND_CLEAN:      cond_hit = !dirty_reg;
            COND_CLR_MORE:   cond_hit = (clr_addr_reg != hwm_reg);
            COND_NO_REQ:     cond_hit = !req_reg;
            COND_CAPPED:     cond_hit = capped;
            COND_OVER:       cond_hit = over;
            COND_PRIME:      cond_hit = !rd_bit_reg;
            COND_MULT_IN:    cond_hit = mult_in;
            default:         cond_hit = 1'b1;
        endcase
        pc_next = cond_hit ? uword.target : pc_reg + 1'b1;
    end

    // datapath actions
    always_comb
    begin
        restart_next  = restart_reg;
        req_next      = req_reg;
        cand_next     = cand_reg;
        count_next    = count_reg;
        mult_next     = mult_reg;
        clr_addr_next = clr_addr_reg;
        hwm_next      = hwm_reg;
        dirty_next    = dirty_reg;
        valid_next    = 1'b0;
        value_next    = value_reg;
        index_next    = index_reg;
        done_next     = done_reg;
        mem_we        = 1'b0;
        mem_waddr     = clr_addr_reg;
        mem_wdata     = 1'b0;

        unique case (uword.act)
            ACT_NONE:
            begin
            end
            ACT_ACCEPT:
            begin
                // request transfer taken while idle
                if (start)
                begin
                    restart_next = restart;
                    req_next     = 1'b1;
                end
            end
            ACT_RUN_INIT:
            begin
                cand_next     = CW'(2);
                count_next    = '0;
                clr_addr_next = '0;
            end
            ACT_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = 1'b0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            ACT_CLEAN:
            begin
                dirty_next = 1'b0;
                hwm_next   = '0;
            end
            ACT_CAND_INC:
            begin
                cand_next = cand_reg + 1'b1;
            end
            ACT_EMIT_PRIME:
            begin
                valid_next = 1'b1;
                value_next = cand_pad[VALUE_W-1:0];
                index_next = count_reg[INDEX_W-1:0];
                done_next  = 1'b0;
                count_next = count_reg + 1'b1;
                req_next   = 1'b0;
                mult_next  = square;
            end
            ACT_MARK:
            begin
                // mark multiples from the square upward, one per cycle
                if (mult_in)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = mult_reg[AW-1:0];
                    mem_wdata  = 1'b1;
                    mult_next  = mult_reg + MW'(cand_lo);
                    dirty_next = 1'b1;
                    if (mult_reg[AW-1:0] > hwm_reg)
                    begin
                        hwm_next = mult_reg[AW-1:0];
                    end
                end
            end
            ACT_EMIT_DONE:
            begin
                valid_next = 1'b1;
                value_next = '0;
                index_next = '0;
                done_next  = 1'b1;
                req_next   = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/psg_checker.sv @@
// port-level checks for the prime sieve generator, bound to its top level
// depends on prime_sieve_generator_top_defines.svh
`default_nettype none

`include "prime_sieve_generator_top_defines.svh"

module psg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        valid,
    input wire logic [19:0] prime_value,
    input wire logic [15:0] prime_index,
    input wire logic        done_res
);

    // a result only ever follows a cycle of work
    `PSG_ASSERT_SAME(a_result_after_busy, valid, $past(busy))
    // a request transfer always starts work
    `PSG_ASSERT_NEXT(a_start_sets_busy, start && !busy, busy)
    // a done result carries no prime
    `PSG_ASSERT_SAME(a_done_is_empty, valid && done_res, prime_value == 20'd0 && prime_index == 16'd0)
    // a prime is at least two
    `PSG_ASSERT_SAME(a_prime_min, valid && !done_res, prime_value >= 20'd2)
    // strobes never come back to back
    `PSG_ASSERT_NEXT(a_single_strobe, valid, !valid)

endmodule

bind prime_sieve_generator_top psg_checker u_psg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .valid       (valid),
    .prime_value (prime_value),
    .prime_index (prime_index),
    .done_res    (done_res)
);

`default_nettype wire

@@ tb/sv/prime_sieve_checker.sv @@
`timescale 1ns / 1ps
// result checker for the prime sieve generator: keeps its own sieve, predicts the result
// of every request transfer and compares the strobed results in order
// depends on psg_pkg

module prime_sieve_checker
    import psg_pkg::*;
#(
    parameter int SIEVE_SIZE = 1048576,
    parameter int MAX_COUNT  = 65536
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 restart,
    input  wire logic                 busy,
    input  wire logic                 valid,
    input  wire logic [VALUE_W-1:0]   prime_value,
    input  wire logic [INDEX_W-1:0]   prime_index,
    input  wire logic                 done_res,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output int                        fail_count,
    output int                        results_due
);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        logic               done;
    } sieve_result_t;

    bit                 composite [SIEVE_SIZE];
    int unsigned        candidate;
    int unsigned        handed_out;
    logic [LIMIT_W-1:0] limit_reg;
    logic [MAXC_W-1:0]  count_cap_reg;
    sieve_result_t      primes_due [$];
    int                 failures  = 0;
    int                 result_no = 0;

    function automatic void clear_sieve();
        for (int n = 0; n < SIEVE_SIZE; n++)
            composite[n] = 1'b0;
        candidate  = 2;
        handed_out = 0;
    endfunction

    // next prime (or done) for one request, updating the mirrored sieve
    function automatic sieve_result_t sieve_next(input logic with_restart);
        sieve_result_t     r;
        int unsigned       lim;
        int unsigned       cap;
        int unsigned       p;
        longint unsigned   m;
        r.value = '0;
        r.index = '0;
        r.done  = 1'b1;
        if (with_restart)
            clear_sieve();
        lim = (limit_reg > SIEVE_SIZE - 1) ? SIEVE_SIZE - 1 : limit_reg;
        cap = (count_cap_reg > MAX_COUNT) ? MAX_COUNT : count_cap_reg;
        // done is sticky: pointer and count stay put
        if (handed_out >= cap)
            return r;
        while (candidate <= lim && composite[candidate])
            candidate++;
        if (candidate > lim)
            return r;
        p = candidate;
        r.value = p[VALUE_W-1:0];
        r.index = handed_out[INDEX_W-1:0];
        r.done  = 1'b0;
        handed_out = (handed_out + 1) & 32'h1FFFF;
        for (m = longint'(p) * p; m <= lim; m += p)
            composite[m] = 1'b1;
        candidate = (p + 1) & 32'h1FFFFF;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        sieve_result_t want;
        if (!rst_n)
        begin
            primes_due.delete();
            clear_sieve();
            limit_reg     = LIMIT_RESET;
            count_cap_reg = MAXC_RESET;
        end
        else
        begin
            // results first: a result never belongs to a request taken at the same edge
            if (valid)
            begin
                result_no++;
                if (primes_due.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("result %0d with nothing due: value %0d index %0d done %0b",
                                 result_no, prime_value, prime_index, done_res);
                end
                else
                begin
                    want = primes_due.pop_front();
                    if (want.value !== prime_value || want.index !== prime_index ||
                        want.done !== done_res)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display({"result %0d mismatch: expected value %0d index %0d",
                                      " done %0b, got value %0d index %0d done %0b"},
                                     result_no, want.value, want.index, want.done,
                                     prime_value, prime_index, done_res);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LIMIT:     limit_reg     = cfg_data[LIMIT_W-1:0];
                    CFG_MAX_COUNT: count_cap_reg = cfg_data[MAXC_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                primes_due.push_back(sieve_next(restart));
        end
        fail_count  <= failures;
        results_due <= primes_due.size();
    end

endmodule

@@ tb/sv/tb_prime_sieve_generator_top.sv @@
`timescale 1ns / 1ps
// testbench top for the prime sieve generator: clock, reset, request and register stimulus
// depends on psg_pkg, prime_sieve_generator_top and prime_sieve_checker

module tb_prime_sieve_generator_top;
    import psg_pkg::*;

    // a small sieve keeps the clearing passes short and lets limits run past the sieve;
    // a low count cap lets long runs reach it
    localparam int SIEVE        = 2048;
    localparam int CAP          = 200;
    localparam int RANDOM_ITEMS = 850;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 restart   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_LIMIT;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 busy;
    logic                 valid;
    logic [VALUE_W-1:0]   prime_value;
    logic [INDEX_W-1:0]   prime_index;
    logic                 done_res;

    int fail_count;
    int results_due;
    int items_sent = 0;
    // chance in percent that the sender pauses before a request, drawn again after each pause
    int gap_pct    = 31;

    always #6 clk = ~clk;

    prime_sieve_generator_top #(
        .SIEVE_SIZE (SIEVE),
        .MAX_COUNT  (CAP)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .restart     (restart),
        .busy        (busy),
        .valid       (valid),
        .prime_value (prime_value),
        .prime_index (prime_index),
        .done_res    (done_res),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    prime_sieve_checker #(
        .SIEVE_SIZE (SIEVE),
        .MAX_COUNT  (CAP)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .restart     (restart),
        .busy        (busy),
        .valid       (valid),
        .prime_value (prime_value),
        .prime_index (prime_index),
        .done_res    (done_res),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    // all tasks start and end on a falling edge

    // one register write, then the enable is dropped and held low before return, so back-to-back
    // writes never lower and raise the enable in the same step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // one request transfer: optional idle cycles, then start held until busy is low
    // at a rising edge; start stays high on return so a following request runs on
    task automatic send_request(input logic with_restart);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        restart <= with_restart;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // stop requesting and wait until every result is in and the marking pass has ended,
    // so the block is idle and the registers may be written
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (results_due != 0 || busy);
        @(negedge clk);
    endtask

    // give up long after the slowest correct run would have ended
    initial
    begin
        #240_000_000;
        $display("tb_prime_sieve_generator_top: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        int                 first_random;
        int                 n;
        int                 pick;
        int                 run_len;
        logic [LIMIT_W-1:0] new_limit;
        logic [CFG_W-1:0]   new_data;

        // reset once, then let the clearing pass finish
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(negedge clk);
        settle();

        // register reset values: limit far past the sieve, cap above the build cap
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);

        // limits below two report done straight away
        settle();
        write_reg(CFG_LIMIT, 20'd0);
        send_request(1'b1);
        send_request(1'b0);
        settle();
        write_reg(CFG_LIMIT, 20'd1);
        send_request(1'b1);

        // smallest useful limit: one prime, then done that stays done
        settle();
        write_reg(CFG_LIMIT, 20'd2);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);

        // zero cap, then a cap of one
        settle();
        write_reg(CFG_MAX_COUNT, 20'd0);
        write_reg(CFG_LIMIT, 20'd100);
        send_request(1'b1);
        settle();
        write_reg(CFG_MAX_COUNT, 20'd1);
        send_request(1'b1);
        send_request(1'b0);

        // all-ones data: cap beyond the build cap, spare data bits set
        settle();
        write_reg(CFG_MAX_COUNT, 20'hFFFFF);
        write_reg(CFG_LIMIT, 20'd10);
        send_request(1'b1);
        repeat (4) send_request(1'b0);

        // limit raised mid-run without a restart: unmarked composites may come out
        settle();
        write_reg(CFG_LIMIT, 20'd30);
        repeat (4) send_request(1'b0);

        // limit lowered mid-run ends the run
        settle();
        write_reg(CFG_LIMIT, 20'd5);
        send_request(1'b0);

        settle();
        write_reg(CFG_MAX_COUNT, 20'h10000);
        write_reg(CFG_LIMIT, 20'hFFFFF);
        send_request(1'b1);

        // random runs: mostly a restart followed by plain requests, with the odd
        // stray restart, runs carried on under new settings, and full pauses
        first_random = items_sent;
        while (items_sent < first_random + RANDOM_ITEMS)
        begin
            n = items_sent - first_random;
            gap_pct = (n < RANDOM_ITEMS / 3) ? 31 : (n < 2 * RANDOM_ITEMS / 3) ? 88 : 0;
            settle();
            if (n == 0 || $urandom_range(0, 99) < 70)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    new_limit = LIMIT_W'($urandom_range(2, 150));
                else if (pick < 85)
                    new_limit = LIMIT_W'($urandom_range(151, SIEVE - 1));
                else if (pick < 90)
                    new_limit = LIMIT_W'($urandom_range(0, 1));
                else
                    new_limit = LIMIT_W'($urandom_range(SIEVE, 20'hFFFFF));
                write_reg(CFG_LIMIT, new_limit);
            end
            if (n == 0 || $urandom_range(0, 99) < 40)
            begin
                new_data = CFG_W'($urandom_range(0, 20'hFFFFF));
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    new_data[MAXC_W-1:0] = MAXC_W'($urandom_range(CAP, 17'h1FFFF));
                else if (pick < 90)
                    new_data[MAXC_W-1:0] = MAXC_W'($urandom_range(1, CAP));
                else
                    new_data[MAXC_W-1:0] = MAXC_W'($urandom_range(0, 5));
                write_reg(CFG_MAX_COUNT, new_data);
            end
            if ($urandom_range(0, 99) < 85)
                send_request(1'b1);
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 320)
                                                 : $urandom_range(4, 60);
            if (run_len > first_random + RANDOM_ITEMS - items_sent)
                run_len = first_random + RANDOM_ITEMS - items_sent;
            repeat (run_len)
            begin
                send_request($urandom_range(0, 99) < 4);
                // now and then hold off until everything outstanding has come back
                if ($urandom_range(0, 39) == 0)
                    settle();
            end
        end

        // drain, then watch a while longer for stray strobes
        settle();
        repeat (4 * SIEVE) @(negedge clk);
        if (fail_count == 0 && results_due == 0)
            $display("tb_prime_sieve_generator_top: done, clean");
        else
            $display("tb_prime_sieve_generator_top: done, errors");
        $finish;
    end

endmodule
